[rtl/core/rmpt_pkg.sv]
// rmpt_pkg: shared types and constants of the running-mean pixel threshold unit
// used by every core module but rmpt_checker, and by the testbench; depends on nothing

package rmpt_pkg;

   localparam int MAX_WINDOW_LOG2 = 8;
   localparam int RING_AW         = MAX_WINDOW_LOG2;
   localparam int RING_DEPTH      = 1 << MAX_WINDOW_LOG2;
   localparam int FILL_W          = MAX_WINDOW_LOG2 + 1;
   localparam int PIXEL_W         = 32;
   localparam int CHAN_W          = 8;
   localparam int CHAN_SUM_W      = CHAN_W + MAX_WINDOW_LOG2;
   localparam int FIELD_SUM_W     = PIXEL_W + MAX_WINDOW_LOG2;
   localparam int LOG2_W          = 4;
   localparam int SHIFT_W         = 4;
   localparam int MAX_SHIFT       = (1 << SHIFT_W) - 1;
   localparam int CHAN_CMP_W      = CHAN_W + MAX_SHIFT;
   localparam int FIELD_CMP_W     = PIXEL_W + MAX_SHIFT;
   localparam int CSR_ADDR_W      = 4;

   localparam logic [PIXEL_W-1:0] RED_MASK   = 32'h00ff_0000;
   localparam logic [PIXEL_W-1:0] GREEN_MASK = 32'h0000_ff00;
   localparam logic [PIXEL_W-1:0] BLUE_MASK  = 32'h0000_00ff;
   localparam logic [PIXEL_W-1:0] ALL_ONES   = 32'hffff_ffff;

   // register reset values
   localparam logic                   MASKED_MODE_RST = 1'b0;
   localparam logic [LOG2_W-1:0]      WINDOW_LOG2_RST = 4'd3;
   localparam logic [SHIFT_W-1:0]     GAIN_SHIFT_RST  = 4'd3;
   localparam logic [PIXEL_W-1:0]     FIELD_MASK_RST  = 32'h0000_00ff;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MASKED_MODE = 4'd0,
      CSR_WINDOW_LOG2 = 4'd1,
      CSR_GAIN_SHIFT  = 4'd2,
      CSR_FIELD_MASK  = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic                   masked_mode;
      logic [LOG2_W-1:0]      window_log2;
      logic [SHIFT_W-1:0]     gain_shift;
      logic [PIXEL_W-1:0]     field_mask;
   } cfg_type;

   // one pixel on its way from the window stage to the threshold stage
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_start;
      logic               need_sub;
      logic [PIXEL_W-1:0] old_pixel;
   } stage_type;

endpackage

[rtl/core/rmpt_csr.sv]
// rmpt_csr: configuration registers of the running-mean pixel threshold unit
// depends on rmpt_pkg

module rmpt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rmpt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rmpt_pkg::PIXEL_W-1:0]    csr_wdata,
   output rmpt_pkg::cfg_type               cfg
);

   rmpt_pkg::cfg_type cfg_ff, cfg_in;

   // writes are taken whenever the unit is out of reset
   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_addr)
            rmpt_pkg::CSR_MASKED_MODE: cfg_in.masked_mode = csr_wdata[0];
            rmpt_pkg::CSR_WINDOW_LOG2:
               cfg_in.window_log2 = csr_wdata[rmpt_pkg::LOG2_W-1:0];
            rmpt_pkg::CSR_GAIN_SHIFT:
               cfg_in.gain_shift = csr_wdata[rmpt_pkg::SHIFT_W-1:0];
            rmpt_pkg::CSR_FIELD_MASK:  cfg_in.field_mask = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.masked_mode <= rmpt_pkg::MASKED_MODE_RST;
         cfg_ff.window_log2 <= rmpt_pkg::WINDOW_LOG2_RST;
         cfg_ff.gain_shift  <= rmpt_pkg::GAIN_SHIFT_RST;
         cfg_ff.field_mask  <= rmpt_pkg::FIELD_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/rmpt_window.sv]
// rmpt_window: window ring memory, fill count and write pointer; first pipeline stage
// depends on rmpt_pkg

module rmpt_window (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            advance,
   input  logic [rmpt_pkg::PIXEL_W-1:0]    pixel,
   input  logic                            row_start,
   input  logic [rmpt_pkg::LOG2_W-1:0]     window_log2,
   output logic                            stage_valid,
   output rmpt_pkg::stage_type             stage
);

   logic [rmpt_pkg::PIXEL_W-1:0] ring [rmpt_pkg::RING_DEPTH];

   logic [rmpt_pkg::RING_AW-1:0]  wptr_ff, wptr_in, wptr_eff, rd_addr;
   logic [rmpt_pkg::FILL_W-1:0]   fill_ff, fill_in, fill_eff, win_len;
   logic [rmpt_pkg::LOG2_W-1:0]   k;
   logic                          valid_ff, valid_in;
   rmpt_pkg::stage_type           stage_ff;

   always_comb begin
      // window length clamps at the ring depth
      k = (window_log2 > rmpt_pkg::LOG2_W'(rmpt_pkg::MAX_WINDOW_LOG2))
          ? rmpt_pkg::LOG2_W'(rmpt_pkg::MAX_WINDOW_LOG2) : window_log2;
      win_len  = rmpt_pkg::FILL_W'(1) << k;
      wptr_eff = row_start ? '0 : wptr_ff;
      fill_eff = row_start ? '0 : fill_ff;
      // a full ring reads back the slot being overwritten, old data first
      rd_addr  = wptr_eff - win_len[rmpt_pkg::RING_AW-1:0];
      wptr_in  = accept ? wptr_eff + rmpt_pkg::RING_AW'(1) : wptr_ff;
      if (!accept) begin
         fill_in = fill_ff;
      end else if (fill_eff == rmpt_pkg::FILL_W'(rmpt_pkg::RING_DEPTH)) begin
         fill_in = fill_eff;
      end else begin
         fill_in = fill_eff + rmpt_pkg::FILL_W'(1);
      end
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         wptr_ff  <= wptr_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring[wptr_eff]     <= pixel;
         stage_ff.old_pixel <= ring[rd_addr];
         stage_ff.pixel     <= pixel;
         stage_ff.row_start <= row_start;
         stage_ff.need_sub  <= (fill_eff >= win_len);
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

[rtl/core/rmpt_thresh.sv]
// rmpt_thresh: running sums, threshold compare and result register; second stage
// depends on rmpt_pkg

module rmpt_thresh (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          out_ready,
   input  rmpt_pkg::stage_type           stage,
   input  rmpt_pkg::cfg_type             cfg,
   output logic                          out_valid,
   output logic [rmpt_pkg::PIXEL_W-1:0]  out_pixel
);

   localparam int CW  = rmpt_pkg::CHAN_SUM_W;
   localparam int FW  = rmpt_pkg::FIELD_SUM_W;
   localparam int CCW = rmpt_pkg::CHAN_CMP_W;
   localparam int FCW = rmpt_pkg::FIELD_CMP_W;

   logic [CW-1:0] red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   logic [FW-1:0] field_ff, field_in;
   logic          valid_ff, valid_in;
   logic [rmpt_pkg::PIXEL_W-1:0] pixel_ff, pixel_in;

   logic [CW-1:0]  red_base, green_base, blue_base;
   logic [FW-1:0]  field_base;
   logic [rmpt_pkg::PIXEL_W-1:0] old_eff, cur_field, old_field, kept;
   logic [CCW-1:0] red_v, green_v, blue_v;
   logic [FCW-1:0] field_v;
   logic           red_gt, green_gt, blue_gt, field_gt;

   always_comb begin
      red_base   = stage.row_start ? '0 : red_ff;
      green_base = stage.row_start ? '0 : green_ff;
      blue_base  = stage.row_start ? '0 : blue_ff;
      field_base = stage.row_start ? '0 : field_ff;
      old_eff    = stage.need_sub ? stage.old_pixel : '0;
      cur_field  = stage.pixel & cfg.field_mask;
      old_field  = old_eff & cfg.field_mask;

      red_in   = red_base - CW'(old_eff[23:16]) + CW'(stage.pixel[23:16]);
      green_in = green_base - CW'(old_eff[15:8]) + CW'(stage.pixel[15:8]);
      blue_in  = blue_base - CW'(old_eff[7:0]) + CW'(stage.pixel[7:0]);
      field_in = field_base - FW'(old_field) + FW'(cur_field);

      red_v   = CCW'(stage.pixel[23:16]) << cfg.gain_shift;
      green_v = CCW'(stage.pixel[15:8]) << cfg.gain_shift;
      blue_v  = CCW'(stage.pixel[7:0]) << cfg.gain_shift;
      field_v = FCW'(cur_field) << cfg.gain_shift;

      red_gt   = red_v > CCW'(red_in);
      green_gt = green_v > CCW'(green_in);
      blue_gt  = blue_v > CCW'(blue_in);
      field_gt = field_v > FCW'(field_in);

      kept = stage.pixel & ~cfg.field_mask;
      if (cfg.masked_mode) begin
         pixel_in = field_gt ? (kept | cfg.field_mask) : kept;
      end else begin
         pixel_in = (red_gt ? rmpt_pkg::RED_MASK : '0)
                  | (green_gt ? rmpt_pkg::GREEN_MASK : '0)
                  | (blue_gt ? rmpt_pkg::BLUE_MASK : '0);
      end

      if (advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         field_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            red_ff   <= red_in;
            green_ff <= green_in;
            blue_ff  <= blue_in;
            field_ff <= field_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

[rtl/core/running_mean_pixel_threshold_unit.sv]
// running_mean_pixel_threshold_unit: top level of the running-mean pixel threshold
// depends on rmpt_pkg, rmpt_csr, rmpt_window, rmpt_thresh

// Thresholds a stream of 32-bit pixels against the mean of a sliding window of
// the last 2^window_log2 input pixels of the current row (the current pixel
// included, partial window near row start). A beat with req_tuser high starts
// a row and clears the window and its sums. In normal mode each color byte
// (bytes 2,1,0 = red, green, blue) becomes 0xff when byte << gain_shift exceeds
// its channel sum, else 0, and the top byte is 0. In masked mode the bits under
// field_mask are compared as one unsigned value against their sum and set or
// cleared; the other bits pass through. One result beat per request beat, in
// order. The unit takes one beat per cycle while rsp is not stalled: the first
// stage writes the pixel into a 256-entry ring memory and reads the pixel
// leaving the window from its single read port, the second stage updates the
// running sums and compares. Back-pressure on rsp holds both stages;
// req_tready then falls once the first stage is occupied. The ring needs no
// clearing after reset because only slots written since the row started are
// read. Write configuration only while no beat is in flight.

module running_mean_pixel_threshold_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [31:0] pixel_in
   input  logic [0:0]                      req_tuser,   // [0] row_start
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [31:0] pixel_out
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rmpt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]                     csr_wdata
);

   rmpt_pkg::cfg_type   cfg;
   rmpt_pkg::stage_type stage;
   logic                stage_valid;
   logic                accept;
   logic                advance;

   // first stage moves on when the result register is empty or draining
   assign advance    = stage_valid && (!rsp_tvalid || rsp_tready);
   assign req_tready = !reset && (!stage_valid || advance);
   assign accept     = req_tvalid && req_tready;

   rmpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ring memory, fill tracking and the outgoing-pixel read
   rmpt_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .pixel       (req_tdata),
      .row_start   (req_tuser[0]),
      .window_log2 (cfg.window_log2),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   // sums, compare and the result register
   rmpt_thresh u_thresh (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .out_ready (rsp_tready),
      .stage     (stage),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_pixel (rsp_tdata)
   );

endmodule

[rtl/core/rmpt_checker.sv]
// rmpt_checker: port-level assertions for the running-mean pixel threshold unit
// bound to running_mean_pixel_threshold_unit; uses only the top-level ports

module rmpt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [31:0]                     rsp_tdata
);

   // a stalled result beat holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no result beat in the cycle after a reset edge
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a new result appears only after a request beat has passed the stage and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result beat without matching request two cycles earlier");

   // with the output stalled, one more request beat fills the pipe
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      && $past(rsp_tvalid && !rsp_tready && req_tvalid && req_tready)
      |-> !req_tready)
      else $error("request accepted with both stages full");

endmodule

bind running_mean_pixel_threshold_unit rmpt_checker u_rmpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/tb_running_mean_pixel_threshold_unit.sv]
// tb_running_mean_pixel_threshold_unit: self-checking testbench of the running-mean
// pixel threshold unit, with its own window and sum predictor in a scoreboard class
// depends on rmpt_pkg and running_mean_pixel_threshold_unit

module tb_running_mean_pixel_threshold_unit;

   // predicts each thresholded pixel from a private copy of the window state
   class thresh_scoreboard;
      logic                             masked;
      logic [rmpt_pkg::LOG2_W-1:0]      win_log2;
      logic [rmpt_pkg::SHIFT_W-1:0]     shift;
      logic [rmpt_pkg::PIXEL_W-1:0]     mask;
      logic [rmpt_pkg::PIXEL_W-1:0]     ring [rmpt_pkg::RING_DEPTH];
      logic [rmpt_pkg::FILL_W-1:0]      fill;
      logic [rmpt_pkg::RING_AW-1:0]     wpos;
      logic [rmpt_pkg::CHAN_SUM_W-1:0]  red_sum;
      logic [rmpt_pkg::CHAN_SUM_W-1:0]  green_sum;
      logic [rmpt_pkg::CHAN_SUM_W-1:0]  blue_sum;
      logic [rmpt_pkg::FIELD_SUM_W-1:0] field_sum;
      logic [rmpt_pkg::PIXEL_W-1:0]     expected_q [$];
      int                               mismatches;

      function new();
         masked     = rmpt_pkg::MASKED_MODE_RST;
         win_log2   = rmpt_pkg::WINDOW_LOG2_RST;
         shift      = rmpt_pkg::GAIN_SHIFT_RST;
         mask       = rmpt_pkg::FIELD_MASK_RST;
         fill       = '0;
         wpos       = '0;
         red_sum    = '0;
         green_sum  = '0;
         blue_sum   = '0;
         field_sum  = '0;
         mismatches = 0;
      endfunction

      function void set_reg(rmpt_pkg::csr_index_type idx, logic [31:0] val);
         case (idx)
            rmpt_pkg::CSR_MASKED_MODE: masked   = val[0];
            rmpt_pkg::CSR_WINDOW_LOG2: win_log2 = val[rmpt_pkg::LOG2_W-1:0];
            rmpt_pkg::CSR_GAIN_SHIFT:  shift    = val[rmpt_pkg::SHIFT_W-1:0];
            rmpt_pkg::CSR_FIELD_MASK:  mask     = val;
            default: ;
         endcase
      endfunction

      function bit chan_hit(logic [rmpt_pkg::CHAN_W-1:0] level,
                            logic [rmpt_pkg::CHAN_SUM_W-1:0] sum);
         return (64'(level) << shift) > 64'(sum);
      endfunction

      function void note_pixel(logic [rmpt_pkg::PIXEL_W-1:0] pix, logic row_start);
         int unsigned                  k;
         logic [rmpt_pkg::FILL_W-1:0]  span;
         logic [rmpt_pkg::PIXEL_W-1:0] old;
         logic [rmpt_pkg::PIXEL_W-1:0] res;
         logic [63:0]                  field_val;
         k    = (win_log2 > rmpt_pkg::MAX_WINDOW_LOG2) ? rmpt_pkg::MAX_WINDOW_LOG2
                                                       : win_log2;
         span = rmpt_pkg::FILL_W'(1 << k);
         if (row_start) begin
            fill      = '0;
            wpos      = '0;
            red_sum   = '0;
            green_sum = '0;
            blue_sum  = '0;
            field_sum = '0;
         end
         // pixel leaving the window once it is full
         if (fill >= span) begin
            old       = ring[rmpt_pkg::RING_AW'(wpos - span[rmpt_pkg::RING_AW-1:0])];
            red_sum   = red_sum   - rmpt_pkg::CHAN_SUM_W'(old[23:16]);
            green_sum = green_sum - rmpt_pkg::CHAN_SUM_W'(old[15:8]);
            blue_sum  = blue_sum  - rmpt_pkg::CHAN_SUM_W'(old[7:0]);
            field_sum = field_sum - rmpt_pkg::FIELD_SUM_W'(old & mask);
         end
         ring[wpos] = pix;
         wpos       = wpos + 1'b1;
         if (fill < rmpt_pkg::FILL_W'(rmpt_pkg::RING_DEPTH))
            fill = fill + 1'b1;
         red_sum   = red_sum   + rmpt_pkg::CHAN_SUM_W'(pix[23:16]);
         green_sum = green_sum + rmpt_pkg::CHAN_SUM_W'(pix[15:8]);
         blue_sum  = blue_sum  + rmpt_pkg::CHAN_SUM_W'(pix[7:0]);
         field_sum = field_sum + rmpt_pkg::FIELD_SUM_W'(pix & mask);
         if (masked) begin
            field_val = 64'(pix & mask);
            res = ((field_val << shift) > 64'(field_sum)) ? (mask | (pix & ~mask))
                                                          : (pix & ~mask);
         end else begin
            res = {8'h00,
                   chan_hit(pix[23:16], red_sum)  ? 8'hff : 8'h00,
                   chan_hit(pix[15:8],  green_sum) ? 8'hff : 8'h00,
                   chan_hit(pix[7:0],   blue_sum)  ? 8'hff : 8'h00};
         end
         expected_q.push_back(res);
      endfunction

      function void flag(string what, logic [rmpt_pkg::PIXEL_W-1:0] want,
                         logic [rmpt_pkg::PIXEL_W-1:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: %s, pixel_out expected %h got %h", what, want, got);
      endfunction

      function void check_result(logic [rmpt_pkg::PIXEL_W-1:0] got);
         logic [rmpt_pkg::PIXEL_W-1:0] want;
         if (expected_q.size() == 0) begin
            flag("result beat with nothing outstanding", 'x, got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want)
               flag("wrong pixel", want, got);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   localparam int RANDOM_BEATS   = 1650;
   localparam int PHASE_BEATS    = 140;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PCT       = 35;

   // dut ports, every input known from time zero
   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata  = '0;   // [31:0] pixel_in
   logic [0:0]                      req_tuser  = '0;   // [0] row_start
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [31:0]                     rsp_tdata;         // [31:0] pixel_out
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [rmpt_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [31:0]                     csr_wdata  = '0;

   thresh_scoreboard sb = new();

   bit          idle_on     = 1'b1;  // random gaps on both sides
   int          quiet_cycles = 0;    // cycles since the last accepted beat of any kind
   logic [31:0] row_base    = '0;    // brightness level of the current row
   logic [31:0] last_pixel  = '0;

   running_mean_pixel_threshold_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // monitor: every handshake is taken at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.set_reg(rmpt_pkg::csr_index_type'(csr_addr), csr_wdata);
         // input is noted first, a result can never belong to the same edge
         if (req_tvalid && req_tready)
            sb.note_pixel(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, none during the steady stretch
   always @(negedge clock) begin
      rsp_tready <= !reset && (!idle_on || $urandom_range(99) >= IDLE_PCT);
   end

   // watchdog: too long with no beat accepted anywhere means the unit hung
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      $display("FAILURE");
      $finish;
   end

   // one request beat; entered and left at a falling edge
   task send_beat(input logic [31:0] pix, input logic row_start);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= pix;
      req_tuser[0] <= row_start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // holds the sender until every outstanding pixel is back, then lets the
   // two pipeline stages settle
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // writes all four registers back to back, only while nothing is in flight
   task write_settings(input logic mode, input logic [3:0] win, input logic [3:0] gain,
                       input logic [31:0] fmask);
      rmpt_pkg::csr_index_type idx  [4];
      logic [31:0]             vals [4];
      idx  = '{rmpt_pkg::CSR_MASKED_MODE, rmpt_pkg::CSR_WINDOW_LOG2,
               rmpt_pkg::CSR_GAIN_SHIFT, rmpt_pkg::CSR_FIELD_MASK};
      vals = '{32'(mode), 32'(win), 32'(gain), fmask};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // mix of fully random, per-byte extremes, row-level texture and repeats
   // (repeats hit the case where the shifted value equals the sum)
   function automatic logic [31:0] next_pixel();
      logic [31:0] pix;
      case ($urandom_range(3))
         0: pix = $urandom;
         1: begin
            pix = $urandom;
            for (int b = 0; b < 4; b++)
               case ($urandom_range(2))
                  0: pix[b*8 +: 8] = 8'h00;
                  1: pix[b*8 +: 8] = 8'hff;
                  default: ;
               endcase
         end
         2: pix = row_base ^ ($urandom & 32'h0f0f_0f0f);
         default: pix = last_pixel;
      endcase
      last_pixel = pix;
      return pix;
   endfunction

   // mostly short rows, some long enough to fill and wrap the widest window
   function automatic int row_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return $urandom_range(1, 48);
      else if (pick < 97)
         return $urandom_range(49, 300);
      else
         return $urandom_range(300, 600);
   endfunction

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(5))
         0: return rmpt_pkg::ALL_ONES;
         1: return '0;
         2: return rmpt_pkg::BLUE_MASK;
         3: return rmpt_pkg::RED_MASK | rmpt_pkg::GREEN_MASK;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int   random_beats;
      int   phase_beats;
      int   phase;
      int   len;
      bit   keep_row;
      bit   paused;
      logic rs;
      logic mode;
      logic [3:0] win;
      logic [3:0] gain;
      logic [31:0] fmask;

      // reset held from time zero, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset settings: first beats carry no row start
      send_beat(32'h0000_0000, 1'b0);
      send_beat(32'hffff_ffff, 1'b0);
      send_beat(32'h00ff_00ff, 1'b0);
      send_beat(32'h0000_ff00, 1'b0);
      // flat row: partial window passes, full window of equal pixels does not
      send_beat(32'h0010_1010, 1'b1);
      repeat (8) send_beat(32'h0010_1010, 1'b0);

      // directed, masked mode switched in mid-row; sums must already be live
      drain();
      write_settings(1'b1, 4'd3, 4'd3, rmpt_pkg::ALL_ONES);
      repeat (4) send_beat($urandom, 1'b0);
      send_beat(32'hffff_ffff, 1'b1);
      send_beat(32'h0000_0000, 1'b0);
      send_beat(32'h8000_0000, 1'b0);

      // random phases, each with its own settings; the mid-row pause and the
      // full-rate phase always come up
      random_beats = 0;
      phase        = 0;
      paused       = 1'b0;
      while (random_beats < RANDOM_BEATS || phase < 8) begin
         case (phase)
            0: begin mode = 1'b0; win = 4'd0;  gain = 4'd0;  fmask = '0; end
            1: begin
               mode = 1'b1; win = 4'd8; gain = 4'd15; fmask = rmpt_pkg::ALL_ONES;
            end
            // windows wider than the ring clamp to the ring depth
            2: begin
               mode = 1'b0; win = 4'd15; gain = 4'd15; fmask = rmpt_pkg::ALL_ONES;
            end
            3: begin mode = 1'b1; win = 4'd12; gain = 4'd0;  fmask = '0;       end
            4: begin mode = 1'b1; win = 4'd3;  gain = 4'd3;  fmask = 32'h00ff_00ff; end
            default: begin
               mode  = 1'($urandom_range(1));
               win   = 4'($urandom_range(15));
               gain  = 4'($urandom_range(15));
               fmask = pick_mask();
            end
         endcase
         drain();
         write_settings(mode, win, gain, fmask);
         idle_on  = (phase != 7);          // one phase at full rate on both sides
         keep_row = (phase % 3 == 2);      // carry the row over a settings change
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS) begin
            len = row_length();
            for (int j = 0; j < len; j++) begin
               // occasional stray row start breaks a row short
               rs = (j == 0 && !keep_row) || ($urandom_range(99) < 2);
               if (rs)
                  row_base = $urandom;
               // once, hold the sender mid-row until the unit has emptied
               if (phase == 6 && !paused && j == len / 2 && len > 4) begin
                  drain();
                  paused = 1'b1;
               end
               send_beat(next_pixel(), rs);
            end
            keep_row    = 1'b0;
            phase_beats += len;
         end
         random_beats += phase_beats;
         phase++;
      end

      // wait for the last results, then a few cycles for anything stray
      req_tvalid <= 1'b0;
      idle_on = 1'b1;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rmpt_pkg.sv
rtl/core/rmpt_csr.sv
rtl/core/rmpt_window.sv
rtl/core/rmpt_thresh.sv
rtl/core/running_mean_pixel_threshold_unit.sv
rtl/core/rmpt_checker.sv
tb/tb_running_mean_pixel_threshold_unit.sv
